[hw/rtl/fla_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
package fla_pkg;

    localparam int HEADER_BYTES = 8;
    localparam int NODE_BYTES   = 16;
    localparam int ALIGN_BYTES  = 8;
    localparam int ALIGN_SHIFT  = 3;
    localparam int HEAP_LIMIT   = 32768;
    localparam int HEAP_MIN     = 32;
    localparam int OFF_W        = 15;
    localparam int LEN_W        = 16;
    localparam int NEED_W       = 17;
    localparam int BLK_DEPTH    = HEAP_LIMIT / ALIGN_BYTES;

    localparam logic FUNC_ALLOC = 1'b0;
    localparam logic FUNC_FREE  = 1'b1;

    localparam logic REG_FIT_POLICY = 1'b0;
    localparam logic REG_HEAP_BYTES = 1'b1;

    typedef enum logic [1:0] {
        ST_OK     = 2'd0,
        ST_NO_FIT = 2'd1,
        ST_FULL   = 2'd2
    } status_t;

    typedef struct packed {
        logic              func;
        logic [LEN_W-1:0]  request_bytes;
        logic [OFF_W-1:0]  release_offset;
    } req_t;

    typedef struct packed {
        status_t           status;
        logic [OFF_W-1:0]  payload_offset;
        logic [LEN_W-1:0]  granted_bytes;
    } rsp_t;

    typedef struct packed {
        logic [OFF_W-1:0]  start;
        logic [LEN_W-1:0]  length;
    } seg_t;

endpackage
`default_nettype wire

[hw/rtl/fla_ram.sv]
`timescale 1ns / 1ps
`default_nettype none
module fla_ram #(
    parameter int DEPTH = 64,
    parameter int WIDTH = 31
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // one write and one registered read per cycle
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule
`default_nettype wire

[hw/rtl/free_list_heap_allocator_top.sv]
`timescale 1ns / 1ps
`default_nettype none
// Free-list heap allocator over a managed byte range.
// Input channel req/req_valid/req_stall carries one item: func selects
// allocate (request_bytes) or free (release_offset). Output channel
// rsp/rsp_valid/rsp_stall returns exactly one item per input item: status,
// payload_offset and granted_bytes.
// Configuration: cfg_we writes cfg_data to register cfg_index (0 fit policy,
// 1 heap size, clamped; a heap write also resets the free table to one
// segment). Write only while the block is idle.
// Sequencing: allocates, and frees that pass the offset checks, scan the
// segment table (count = free segments held, at most MAX_SEGMENTS), and
// the table is shifted when a segment is removed or inserted. The segment
// memory, with one write and one read port, is read one entry per cycle
// by the scan and shift sequencer. One item at a time.
// Reset: after reset the block first seeds the first segment (S_INIT);
// it then holds one free segment covering the whole heap.
// A stalled result is held in the output register; the next item is
// accepted meanwhile, but its result waits until the register frees up.
module free_list_heap_allocator_top #(
    parameter int MAX_SEGMENTS = 64
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_we,
    input  logic                            cfg_index,
    input  logic [fla_pkg::LEN_W-1:0]       cfg_data,
    input  logic                            req_valid,
    output logic                            req_stall,
    input  fla_pkg::req_t                   req,
    output logic                            rsp_valid,
    input  logic                            rsp_stall,
    output fla_pkg::rsp_t                   rsp
);

    import fla_pkg::*;

    localparam int AW = $clog2(MAX_SEGMENTS);
    localparam int CW = $clog2(MAX_SEGMENTS + 1);
    localparam int BW = $clog2(BLK_DEPTH);

    // sequencer states
    typedef enum logic [9:0] {
        S_INIT   = 10'b0000000001,
        S_IDLE   = 10'b0000000010,
        S_LCHK   = 10'b0000000100,
        S_SCAN   = 10'b0000001000,
        S_ADEC   = 10'b0000010000,
        S_FDEC   = 10'b0000100000,
        S_MOVE   = 10'b0001000000,
        S_FIN    = 10'b0010000000,
        S_RESULT = 10'b0100000000,
        S_SPARE  = 10'b1000000000
    } state_t;

    state_t state_reg, state_next;

    logic              fit_reg, fit_next;
    logic [LEN_W-1:0]  heap_reg, heap_next;
    logic [CW-1:0]     count_reg, count_next;
    logic              op_reg, op_next;
    logic [OFF_W-1:0]  off_reg, off_next;
    logic [OFF_W-1:0]  base_reg, base_next;
    logic [NEED_W-1:0] need_reg, need_next;
    logic [LEN_W-1:0]  len_reg, len_next;
    logic [NEED_W-1:0] stop_reg, stop_next;
    logic [CW-1:0]     ptr_reg, ptr_next;
    logic              pv_reg, pv_next;
    logic [CW-1:0]     pidx_reg, pidx_next;
    logic [CW-1:0]     remain_reg, remain_next;
    logic              asc_reg, asc_next;
    logic              ins_reg, ins_next;
    logic              found_reg, found_next;
    logic [CW-1:0]     pick_reg, pick_next;
    logic [OFF_W-1:0]  best_s_reg, best_s_next;
    logic [LEN_W-1:0]  best_l_reg, best_l_next;
    logic              reject_reg, reject_next;
    logic              pfound_reg, pfound_next;
    logic [CW-1:0]     pos_reg, pos_next;
    logic [OFF_W-1:0]  pos_s_reg, pos_s_next;
    logic [LEN_W-1:0]  pos_l_reg, pos_l_next;
    logic [OFF_W-1:0]  prev_s_reg, prev_s_next;
    logic [LEN_W-1:0]  prev_l_reg, prev_l_next;
    logic [OFF_W-1:0]  last_s_reg, last_s_next;
    logic [LEN_W-1:0]  last_l_reg, last_l_next;
    rsp_t              res_reg, res_next;
    rsp_t              rsp_reg, rsp_next;
    logic              rsp_valid_reg, rsp_valid_next;

    // segment table memory
    logic              seg_we;
    logic [AW-1:0]     seg_waddr;
    seg_t              seg_wdata;
    logic              seg_re;
    logic [AW-1:0]     seg_raddr;
    seg_t              seg_rdata;

    // granted length per block
    logic              bl_we;
    logic [BW-1:0]     bl_waddr;
    logic [LEN_W-1:0]  bl_wdata;
    logic              bl_re;
    logic [BW-1:0]     bl_raddr;
    logic [LEN_W-1:0]  bl_rdata;

    fla_ram #(.DEPTH(MAX_SEGMENTS), .WIDTH($bits(seg_t))) u_seg_ram (
        .clk   (clk),
        .we    (seg_we),
        .waddr (seg_waddr),
        .wdata (seg_wdata),
        .re    (seg_re),
        .raddr (seg_raddr),
        .rdata (seg_rdata)
    );

    fla_ram #(.DEPTH(BLK_DEPTH), .WIDTH(LEN_W)) u_blk_ram (
        .clk   (clk),
        .we    (bl_we),
        .waddr (bl_waddr),
        .wdata (bl_wdata),
        .re    (bl_re),
        .raddr (bl_raddr),
        .rdata (bl_rdata)
    );

    // datapath helpers
    logic [NEED_W-1:0] total_w, pad_w, need_w;
    logic [OFF_W-1:0]  rel_base_w;
    logic [NEED_W-1:0] stop_w;
    logic [NEED_W-1:0] seg_end_w;
    logic [NEED_W:0]   split_min_w;
    logic              split_w;
    logic [NEED_W-1:0] split_start_w, split_len_w;
    logic [CW-1:0]     pos_eff_w;
    logic [OFF_W-1:0]  prev_s_eff_w;
    logic [LEN_W-1:0]  prev_l_eff_w;
    logic [NEED_W-1:0] prev_end_w;
    logic              join_up_w, join_down_w;
    logic [NEED_W-1:0] nl_w, merged_w;
    logic [LEN_W-1:0]  clamp_w;

    assign total_w    = NEED_W'(HEADER_BYTES) + {1'b0, req.request_bytes};
    assign pad_w      = (NEED_W'(ALIGN_BYTES) - (total_w & NEED_W'(ALIGN_BYTES - 1)))
                        & NEED_W'(ALIGN_BYTES - 1);
    assign need_w     = {1'b0, req.request_bytes} + pad_w;
    assign rel_base_w = req.release_offset - OFF_W'(HEADER_BYTES);
    assign stop_w     = {2'b00, base_reg} + NEED_W'(HEADER_BYTES) + {1'b0, bl_rdata};
    assign seg_end_w  = {2'b00, seg_rdata.start} + NEED_W'(HEADER_BYTES)
                        + {1'b0, seg_rdata.length};

    assign split_min_w   = {1'b0, need_reg} + (NEED_W + 1)'(NODE_BYTES + 1);
    assign split_w       = {2'b00, best_l_reg} >= split_min_w;
    assign split_start_w = {2'b00, best_s_reg} + NEED_W'(HEADER_BYTES) + need_reg;
    assign split_len_w   = {1'b0, best_l_reg} - NEED_W'(HEADER_BYTES) - need_reg;

    // with no higher segment the insertion point is the table end
    assign pos_eff_w    = pfound_reg ? pos_reg : count_reg;
    assign prev_s_eff_w = pfound_reg ? prev_s_reg : last_s_reg;
    assign prev_l_eff_w = pfound_reg ? prev_l_reg : last_l_reg;
    assign prev_end_w   = {2'b00, prev_s_eff_w} + NEED_W'(HEADER_BYTES)
                          + {1'b0, prev_l_eff_w};
    assign join_up_w    = pfound_reg && ({2'b00, pos_s_reg} == stop_reg);
    assign join_down_w  = (pos_eff_w != '0) && (prev_end_w == {2'b00, base_reg});
    assign nl_w         = {1'b0, len_reg}
                          + (join_up_w ? NEED_W'(HEADER_BYTES) + {1'b0, pos_l_reg}
                                       : '0);
    assign merged_w     = {1'b0, prev_l_eff_w} + NEED_W'(HEADER_BYTES) + nl_w;

    assign clamp_w = (cfg_data < LEN_W'(HEAP_MIN))   ? LEN_W'(HEAP_MIN)   :
                     (cfg_data > LEN_W'(HEAP_LIMIT)) ? LEN_W'(HEAP_LIMIT) : cfg_data;

    always_comb
    begin
        state_next    = state_reg;
        fit_next      = fit_reg;
        heap_next     = heap_reg;
        count_next    = count_reg;
        op_next       = op_reg;
        off_next      = off_reg;
        base_next     = base_reg;
        need_next     = need_reg;
        len_next      = len_reg;
        stop_next     = stop_reg;
        ptr_next      = ptr_reg;
        pv_next       = 1'b0;
        pidx_next     = pidx_reg;
        remain_next   = remain_reg;
        asc_next      = asc_reg;
        ins_next      = ins_reg;
        found_next    = found_reg;
        pick_next     = pick_reg;
        best_s_next   = best_s_reg;
        best_l_next   = best_l_reg;
        reject_next   = reject_reg;
        pfound_next   = pfound_reg;
        pos_next      = pos_reg;
        pos_s_next    = pos_s_reg;
        pos_l_next    = pos_l_reg;
        prev_s_next   = prev_s_reg;
        prev_l_next   = prev_l_reg;
        last_s_next   = last_s_reg;
        last_l_next   = last_l_reg;
        res_next      = res_reg;
        rsp_next      = rsp_reg;
        rsp_valid_next = rsp_valid_reg && rsp_stall;

        seg_we    = 1'b0;
        seg_waddr = '0;
        seg_wdata = '0;
        seg_re    = 1'b0;
        seg_raddr = ptr_reg[AW-1:0];
        bl_we     = 1'b0;
        bl_waddr  = best_s_reg[OFF_W-1:ALIGN_SHIFT];
        bl_wdata  = '0;
        bl_re     = 1'b0;
        bl_raddr  = rel_base_w[OFF_W-1:ALIGN_SHIFT];

        case (state_reg)
            S_INIT:
            begin
                // seed the single segment spanning the heap
                seg_we     = 1'b1;
                seg_wdata  = '{start: '0, length: heap_reg - LEN_W'(HEADER_BYTES)};
                state_next = S_IDLE;
            end
            S_IDLE:
            begin
                if (req_valid)
                begin
                    op_next     = req.func;
                    off_next    = req.release_offset;
                    base_next   = rel_base_w;
                    need_next   = need_w;
                    ptr_next    = '0;
                    found_next  = 1'b0;
                    reject_next = 1'b0;
                    pfound_next = 1'b0;
                    last_s_next = '0;
                    last_l_next = '0;
                    if (req.func == FUNC_ALLOC)
                    begin
                        state_next = S_SCAN;
                    end
                    else if ((req.release_offset < OFF_W'(HEADER_BYTES))
                             || (rel_base_w[ALIGN_SHIFT-1:0] != '0)
                             || ({1'b0, rel_base_w} >= heap_reg))
                    begin
                        res_next   = '{status: ST_NO_FIT, payload_offset: '0,
                                       granted_bytes: '0};
                        state_next = S_RESULT;
                    end
                    else
                    begin
                        bl_re      = 1'b1;
                        state_next = S_LCHK;
                    end
                end
            end
            S_LCHK:
            begin
                len_next  = bl_rdata;
                stop_next = stop_w;
                if (stop_w > {1'b0, heap_reg})
                begin
                    res_next   = '{status: ST_NO_FIT, payload_offset: '0,
                                   granted_bytes: '0};
                    state_next = S_RESULT;
                end
                else
                begin
                    state_next = S_SCAN;
                end
            end
            S_SCAN:
            begin
                // issue one read a cycle, examine the entry read last cycle
                if (ptr_reg < count_reg)
                begin
                    seg_re    = 1'b1;
                    ptr_next  = ptr_reg + 1'b1;
                    pv_next   = 1'b1;
                    pidx_next = ptr_reg;
                end
                if (pv_reg)
                begin
                    if (op_reg == FUNC_ALLOC)
                    begin
                        if (({1'b0, seg_rdata.length} >= need_reg)
                            && (!found_reg
                                || (fit_reg && (seg_rdata.length < best_l_reg))))
                        begin
                            found_next  = 1'b1;
                            pick_next   = pidx_reg;
                            best_s_next = seg_rdata.start;
                            best_l_next = seg_rdata.length;
                        end
                    end
                    else
                    begin
                        if (({2'b00, base_reg} < seg_end_w)
                            && ({2'b00, seg_rdata.start} < stop_reg))
                        begin
                            reject_next = 1'b1;
                        end
                        if (!pfound_reg && (seg_rdata.start > base_reg))
                        begin
                            pfound_next = 1'b1;
                            pos_next    = pidx_reg;
                            pos_s_next  = seg_rdata.start;
                            pos_l_next  = seg_rdata.length;
                            prev_s_next = last_s_reg;
                            prev_l_next = last_l_reg;
                        end
                        last_s_next = seg_rdata.start;
                        last_l_next = seg_rdata.length;
                    end
                end
                if ((ptr_reg >= count_reg) && !pv_reg)
                begin
                    state_next = (op_reg == FUNC_ALLOC) ? S_ADEC : S_FDEC;
                end
            end
            S_ADEC:
            begin
                ins_next = 1'b0;
                if (!found_reg)
                begin
                    res_next   = '{status: ST_NO_FIT, payload_offset: '0,
                                   granted_bytes: '0};
                    state_next = S_RESULT;
                end
                else
                begin
                    bl_we = 1'b1;
                    if (split_w)
                    begin
                        // carve the block off the bottom of the segment
                        seg_we     = 1'b1;
                        seg_waddr  = pick_reg[AW-1:0];
                        seg_wdata  = '{start: split_start_w[OFF_W-1:0],
                                       length: split_len_w[LEN_W-1:0]};
                        bl_wdata   = need_reg[LEN_W-1:0];
                        state_next = S_RESULT;
                    end
                    else
                    begin
                        // absorb the whole segment, close the gap
                        bl_wdata    = best_l_reg;
                        count_next  = count_reg - 1'b1;
                        ptr_next    = pick_reg + 1'b1;
                        remain_next = count_reg - 1'b1 - pick_reg;
                        asc_next    = 1'b1;
                        state_next  = S_MOVE;
                    end
                    res_next = '{status: ST_OK,
                                 payload_offset: best_s_reg + OFF_W'(HEADER_BYTES),
                                 granted_bytes: bl_wdata};
                end
            end
            S_FDEC:
            begin
                pos_next = pos_eff_w;
                ins_next = 1'b0;
                if (reject_reg)
                begin
                    res_next   = '{status: ST_NO_FIT, payload_offset: '0,
                                   granted_bytes: '0};
                    state_next = S_RESULT;
                end
                else if (!join_up_w && !join_down_w
                         && (count_reg >= CW'(MAX_SEGMENTS)))
                begin
                    res_next   = '{status: ST_FULL, payload_offset: '0,
                                   granted_bytes: '0};
                    state_next = S_RESULT;
                end
                else
                begin
                    res_next   = '{status: ST_OK, payload_offset: off_reg,
                                   granted_bytes: len_reg};
                    state_next = S_RESULT;
                    if (join_down_w)
                    begin
                        // grow the lower neighbour over the block
                        seg_we    = 1'b1;
                        seg_waddr = AW'(pos_eff_w - 1'b1);
                        seg_wdata = '{start: prev_s_eff_w,
                                      length: merged_w[LEN_W-1:0]};
                        if (join_up_w)
                        begin
                            count_next  = count_reg - 1'b1;
                            ptr_next    = pos_eff_w + 1'b1;
                            remain_next = count_reg - 1'b1 - pos_eff_w;
                            asc_next    = 1'b1;
                            state_next  = S_MOVE;
                        end
                    end
                    else if (join_up_w)
                    begin
                        seg_we    = 1'b1;
                        seg_waddr = pos_eff_w[AW-1:0];
                        seg_wdata = '{start: base_reg, length: nl_w[LEN_W-1:0]};
                    end
                    else
                    begin
                        // open a slot at the insertion point
                        count_next  = count_reg + 1'b1;
                        ptr_next    = count_reg - 1'b1;
                        remain_next = count_reg - pos_eff_w;
                        asc_next    = 1'b0;
                        ins_next    = 1'b1;
                        state_next  = S_MOVE;
                    end
                end
            end
            S_MOVE:
            begin
                if (remain_reg != '0)
                begin
                    seg_re      = 1'b1;
                    ptr_next    = asc_reg ? ptr_reg + 1'b1 : ptr_reg - 1'b1;
                    remain_next = remain_reg - 1'b1;
                    pv_next     = 1'b1;
                    pidx_next   = ptr_reg;
                end
                if (pv_reg)
                begin
                    seg_we    = 1'b1;
                    seg_waddr = asc_reg ? AW'(pidx_reg - 1'b1) : AW'(pidx_reg + 1'b1);
                    seg_wdata = seg_rdata;
                end
                if ((remain_reg == '0) && !pv_reg)
                begin
                    state_next = S_FIN;
                end
            end
            S_FIN:
            begin
                if (ins_reg)
                begin
                    seg_we    = 1'b1;
                    seg_waddr = pos_reg[AW-1:0];
                    seg_wdata = '{start: base_reg, length: len_reg};
                end
                state_next = S_RESULT;
            end
            S_RESULT:
            begin
                // hold until the output register is free
                if (!rsp_valid_reg || !rsp_stall)
                begin
                    rsp_next       = res_reg;
                    rsp_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        if (cfg_we)
        begin
            if (cfg_index == REG_FIT_POLICY)
            begin
                fit_next = cfg_data[0];
            end
            else
            begin
                heap_next  = clamp_w;
                count_next = CW'(1);
                seg_we     = 1'b1;
                seg_waddr  = '0;
                seg_wdata  = '{start: '0, length: clamp_w - LEN_W'(HEADER_BYTES)};
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_INIT;
            fit_reg       <= 1'b0;
            heap_reg      <= LEN_W'(HEAP_LIMIT);
            count_reg     <= CW'(1);
            pv_reg        <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            fit_reg       <= fit_next;
            heap_reg      <= heap_next;
            count_reg     <= count_next;
            pv_reg        <= pv_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg     <= op_next;
        off_reg    <= off_next;
        base_reg   <= base_next;
        need_reg   <= need_next;
        len_reg    <= len_next;
        stop_reg   <= stop_next;
        ptr_reg    <= ptr_next;
        pidx_reg   <= pidx_next;
        remain_reg <= remain_next;
        asc_reg    <= asc_next;
        ins_reg    <= ins_next;
        found_reg  <= found_next;
        pick_reg   <= pick_next;
        best_s_reg <= best_s_next;
        best_l_reg <= best_l_next;
        reject_reg <= reject_next;
        pfound_reg <= pfound_next;
        pos_reg    <= pos_next;
        pos_s_reg  <= pos_s_next;
        pos_l_reg  <= pos_l_next;
        prev_s_reg <= prev_s_next;
        prev_l_reg <= prev_l_next;
        last_s_reg <= last_s_next;
        last_l_reg <= last_l_next;
        res_reg    <= res_next;
        rsp_reg    <= rsp_next;
    end

    assign req_stall = (state_reg != S_IDLE);
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    a_count_bound : assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(MAX_SEGMENTS))
        else $error("segment count beyond table depth");

    a_fail_zero : assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && (rsp.status != ST_OK))
        |-> ((rsp.payload_offset == '0) && (rsp.granted_bytes == '0)))
        else $error("failed item carries payload");

    a_rsp_from_result : assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rsp_valid) |-> $past(state_reg == S_RESULT))
        else $error("result raised outside result state");

endmodule
`default_nettype wire
